/* design/gde_pkg.sv */
// ----------------------------------------------------------------------------
// gde_pkg
// Shared types and constants for the gamepad deadzone and edge conditioner:
// payload structs, configuration register indexes, activity masks.
// ----------------------------------------------------------------------------
`default_nettype none

package gde_pkg;

    // Block sizing
    localparam int NUM_PADS   = 4;
    localparam int NUM_ANALOG = 8;
    localparam int PAD_IDX_W  = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;

    // Field widths fixed by the report format
    localparam int PAD_FIELD_W = 2;
    localparam int BTN_W       = 16;
    localparam int ANA_BYTES   = 8;
    localparam int AXIS_W      = 16;
    localparam int DZ_W        = 16;
    localparam int GAIN_W      = 22;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = CFG_IDX_W'(1);

    localparam logic [DZ_W-1:0]   DEADZONE_RESET = DZ_W'(15728);
    localparam logic [GAIN_W-1:0] GAIN_RESET     = GAIN_W'(86232);

    // Activity masks: dpad, start, back; A, B, X, Y, LT, RT
    localparam logic [BTN_W-1:0]     ACTIVE_DIGITAL_MASK = 16'h003F;
    localparam logic [ANA_BYTES-1:0] ACTIVE_ANALOG_MASK  = 8'hCF;

    typedef struct packed {
        logic [PAD_FIELD_W-1:0] pad_index;
        logic                   connected;
        logic [BTN_W-1:0]       digital_buttons;
        logic [63:0]            analog_buttons;
        logic signed [AXIS_W-1:0] left_stick_x;
        logic signed [AXIS_W-1:0] left_stick_y;
        logic signed [AXIS_W-1:0] right_stick_x;
        logic signed [AXIS_W-1:0] right_stick_y;
    } t_in_item;

    typedef struct packed {
        logic signed [AXIS_W-1:0] scaled_left_x;
        logic signed [AXIS_W-1:0] scaled_left_y;
        logic signed [AXIS_W-1:0] scaled_right_x;
        logic signed [AXIS_W-1:0] scaled_right_y;
        logic [BTN_W-1:0]         new_digital_presses;
        logic [ANA_BYTES-1:0]     new_analog_presses;
        logic                     any_pad_active;
    } t_out_item;

    // Per-pad state update request
    typedef struct packed {
        logic                 conn;
        logic                 commit;
        logic [PAD_IDX_W-1:0] pad;
        logic [BTN_W-1:0]     buttons;
        logic [ANA_BYTES-1:0] pressed;
        logic                 stick_active;
    } t_pad_upd;

    // Per-pad state report
    typedef struct packed {
        logic [BTN_W-1:0]     new_dig;
        logic [ANA_BYTES-1:0] new_ana;
        logic                 any_active;
    } t_pad_rpt;

endpackage

`default_nettype wire

/* design/gde_axis_scale.sv */
// ----------------------------------------------------------------------------
// gde_axis_scale
// One stick axis: symmetric magnitude, deadzone removal, gain rescale with
// saturation at full scale, sign restore.
// ----------------------------------------------------------------------------
`default_nettype none

module gde_axis_scale (
    input  wire logic signed [gde_pkg::AXIS_W-1:0] i_raw,
    input  wire logic [gde_pkg::DZ_W-1:0]          i_deadzone,
    input  wire logic [gde_pkg::GAIN_W-1:0]        i_gain,
    output logic signed [gde_pkg::AXIS_W-1:0]      o_scaled
);

    localparam int PROD_W = gde_pkg::DZ_W + gde_pkg::GAIN_W;

    logic                          neg;
    logic [gde_pkg::AXIS_W-1:0]    folded;
    logic [gde_pkg::DZ_W-1:0]      mag;
    logic [gde_pkg::DZ_W-1:0]      excess;
    logic [PROD_W-1:0]             prod;
    logic                          sat;
    logic [gde_pkg::AXIS_W-2:0]    v;

    // Fold to |2*raw+1|: for negative raw this is 2*(~raw)+1
    assign neg    = i_raw[gde_pkg::AXIS_W-1];
    assign folded = neg ? ~i_raw : i_raw;
    assign mag    = {folded[gde_pkg::AXIS_W-2:0], 1'b1};

    // Drop the deadzone, floor at zero
    assign excess = (mag > i_deadzone) ? (mag - i_deadzone) : '0;

    // Rescale, shift by 17, saturate at 32767
    assign prod = PROD_W'(excess) * PROD_W'(i_gain);
    assign sat  = |prod[PROD_W-1:32];
    assign v    = sat ? '1 : prod[31:17];

    // Restore sign
    assign o_scaled = neg ? -$signed({1'b0, v}) : $signed({1'b0, v});

endmodule

`default_nettype wire

/* design/gde_pad_state.sv */
// ----------------------------------------------------------------------------
// gde_pad_state
// Per-pad history: last buttons, last analog-pressed bits and activity bit.
// Reports new presses and the activity OR over all pads after the update.
// ----------------------------------------------------------------------------
`default_nettype none

module gde_pad_state (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gde_pkg::t_pad_upd i_upd,
    output gde_pkg::t_pad_rpt      o_rpt
);

    logic [gde_pkg::BTN_W-1:0]     r_prev_buttons [gde_pkg::NUM_PADS];
    logic [gde_pkg::ANA_BYTES-1:0] r_prev_analog  [gde_pkg::NUM_PADS];
    logic [gde_pkg::NUM_PADS-1:0]  r_pad_active;
    logic [gde_pkg::NUM_PADS-1:0]  n_pad_active;
    logic                          new_active;

    // Activity of this report
    assign new_active = (|(i_upd.buttons & gde_pkg::ACTIVE_DIGITAL_MASK)) ||
                        (|(i_upd.pressed & gde_pkg::ACTIVE_ANALOG_MASK)) ||
                        i_upd.stick_active;

    // Edge detect against this pad's history
    always_comb begin
        if (i_upd.conn) begin
            o_rpt.new_dig = i_upd.buttons & ~r_prev_buttons[i_upd.pad];
            o_rpt.new_ana = i_upd.pressed & ~r_prev_analog[i_upd.pad];
        end else begin
            o_rpt.new_dig = '0;
            o_rpt.new_ana = '0;
        end
    end

    // Activity bits as they stand after this report
    always_comb begin
        n_pad_active = r_pad_active;
        if (i_upd.conn) begin
            n_pad_active[i_upd.pad] = new_active;
        end
    end

    assign o_rpt.any_active = |n_pad_active;

    // Commit history when the result moves to the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < gde_pkg::NUM_PADS; p++) begin
                r_prev_buttons[p] <= '0;
                r_prev_analog[p]  <= '0;
            end
            r_pad_active <= '0;
        end else if (i_upd.commit && i_upd.conn) begin
            r_prev_buttons[i_upd.pad] <= i_upd.buttons;
            r_prev_analog[i_upd.pad]  <= i_upd.pressed;
            r_pad_active              <= n_pad_active;
        end
    end

    // A disconnected report never shows presses
    a_disc_no_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_upd.conn |-> (o_rpt.new_dig == '0) && (o_rpt.new_ana == '0))
        else $error("presses reported for disconnected pad");

    // A committed report becomes that pad's history
    a_hist_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_upd.commit && i_upd.conn) |=>
            (r_prev_buttons[$past(i_upd.pad)] == $past(i_upd.buttons)))
        else $error("button history not updated");

endmodule

`default_nettype wire

/* design/gamepad_deadzone_edge_conditioner.sv */
// Path: an accepted report is held in the input register, then one pass of
//   logic takes it into the output register, where its result is valid.
// Throughput: one report per cycle while i_out_ready holds; per-pad history
//   is read and written in one pass; consecutive reports of a pad need no stall.
// Reset: synchronous, active low; clears history, activity bits and both
//   pipeline valids, and loads the default deadzone and gain.
// ----------------------------------------------------------------------------
// gamepad_deadzone_edge_conditioner
// Stick deadzone rescale and per-pad button edge detection for poll reports.
// ----------------------------------------------------------------------------
`default_nettype none

module gamepad_deadzone_edge_conditioner (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Report channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire gde_pkg::t_in_item                i_in_item,
    // Result channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output gde_pkg::t_out_item                    o_out_item,
    // Configuration write channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [gde_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [gde_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [gde_pkg::DZ_W-1:0]      r_deadzone;
    logic [gde_pkg::GAIN_W-1:0]    r_gain;

    logic                          r_s1_valid;
    gde_pkg::t_in_item             r_s1_item;
    logic                          r_out_valid;
    gde_pkg::t_out_item            r_out_item;
    gde_pkg::t_out_item            n_out_item;

    logic                          advance;
    logic                          conn;
    logic [gde_pkg::ANA_BYTES-1:0] pressed;
    gde_pkg::t_pad_upd             upd;
    gde_pkg::t_pad_rpt             rpt;

    logic signed [gde_pkg::AXIS_W-1:0] lx, ly, rx, ry;

    // Configuration registers; writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadzone <= gde_pkg::DEADZONE_RESET;
            r_gain     <= gde_pkg::GAIN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gde_pkg::CFG_DEADZONE: r_deadzone <= i_cfg_data[gde_pkg::DZ_W-1:0];
                gde_pkg::CFG_GAIN:     r_gain     <= i_cfg_data[gde_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: stage 1 moves on whenever the output register is free or drains
    assign advance    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    // Hold the accepted report
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_item <= i_in_item;
        end
    end

    // Report is usable only for a connected, existing pad
    assign conn = r_s1_item.connected &&
                  (32'(r_s1_item.pad_index) < gde_pkg::NUM_PADS);

    // Analog button counts as pressed when its byte is nonzero
    always_comb begin
        pressed = '0;
        for (int k = 0; k < gde_pkg::NUM_ANALOG; k++) begin
            pressed[k] = |r_s1_item.analog_buttons[8*k +: 8];
        end
    end

    // Stick axes
    gde_axis_scale u_axis_lx (
        .i_raw      (r_s1_item.left_stick_x),
        .i_deadzone (r_deadzone),
        .i_gain     (r_gain),
        .o_scaled   (lx)
    );

    gde_axis_scale u_axis_ly (
        .i_raw      (r_s1_item.left_stick_y),
        .i_deadzone (r_deadzone),
        .i_gain     (r_gain),
        .o_scaled   (ly)
    );

    gde_axis_scale u_axis_rx (
        .i_raw      (r_s1_item.right_stick_x),
        .i_deadzone (r_deadzone),
        .i_gain     (r_gain),
        .o_scaled   (rx)
    );

    gde_axis_scale u_axis_ry (
        .i_raw      (r_s1_item.right_stick_y),
        .i_deadzone (r_deadzone),
        .i_gain     (r_gain),
        .o_scaled   (ry)
    );

    // Per-pad history and activity
    assign upd.conn         = conn;
    assign upd.commit       = advance;
    assign upd.pad          = gde_pkg::PAD_IDX_W'(r_s1_item.pad_index);
    assign upd.buttons      = r_s1_item.digital_buttons;
    assign upd.pressed      = pressed;
    assign upd.stick_active = (lx != '0) || (ly != '0);

    gde_pad_state u_pad_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (upd),
        .o_rpt   (rpt)
    );

    // Assemble the result; sticks read zero for a disconnected report
    always_comb begin
        n_out_item.scaled_left_x       = conn ? lx : '0;
        n_out_item.scaled_left_y       = conn ? ly : '0;
        n_out_item.scaled_right_x      = conn ? rx : '0;
        n_out_item.scaled_right_y      = conn ? ry : '0;
        n_out_item.new_digital_presses = rpt.new_dig;
        n_out_item.new_analog_presses  = rpt.new_ana;
        n_out_item.any_pad_active      = rpt.any_active;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // An empty pipeline always takes a report
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_s1_valid && !r_out_valid) |-> o_in_ready)
        else $error("ready low with empty pipeline");

    // A held report stays until it moves to the output register
    a_s1_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !advance) |=> (r_s1_valid && $stable(r_s1_item)))
        else $error("stage 1 report lost");

    // Sign restore never produces the most negative code
    a_no_min_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_item.scaled_left_x != 16'sh8000) &&
                        (r_out_item.scaled_left_y != 16'sh8000) &&
                        (r_out_item.scaled_right_x != 16'sh8000) &&
                        (r_out_item.scaled_right_y != 16'sh8000))
        else $error("scaled axis out of range");

endmodule

`default_nettype wire
